// ===== rtl/core/ede_pkg.sv =====
// Shared types and constants for the edit distance engine.
package ede_pkg;

    localparam int MAX_LEN_DEF = 64;
    localparam int SYM_W       = 8;
    localparam int DIST_W      = 7;

    // request kind carried in the func field
    localparam logic FUNC_REF  = 1'b0;
    localparam logic FUNC_CAND = 1'b1;

    // distance field saturates here
    localparam logic [DIST_W-1:0] DIST_SAT = 7'd127;

    // Flags that travel with a wavefront token along the cell chain
    typedef struct packed {
        logic vld;  // token present in this stage
        logic upd;  // token carries a candidate character to fold into the row
        logic rd;   // token asks for the result at the chain end
        logic ovf;  // overflow flag to report with the result
    } t_wave_ctl;

    // Broadcast controls from the top level to every cell
    typedef struct packed {
        logic adv;     // chain moves one stage this cycle
        logic init;    // load row entries with their index (new candidate)
        logic ref_we;  // write one reference character
    } t_cell_ctl;

endpackage

// ===== rtl/core/ede_cell.sv =====
// One cell of the chain: holds one reference character and one row entry.
module ede_cell
    import ede_pkg::*;
#(
    parameter int IDX = 1,
    parameter int LW  = 7,
    parameter int VW  = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_ctl        i_ctl,
    input  logic [LW-1:0]    i_ref_len,
    input  logic [LW-1:0]    i_wr_pos,
    input  logic [SYM_W-1:0] i_ref_sym,
    input  t_wave_ctl        i_wave,
    input  logic [SYM_W-1:0] i_sym,
    input  logic [VW-1:0]    i_left,
    input  logic [VW-1:0]    i_diag,
    output t_wave_ctl        o_wave,
    output logic [SYM_W-1:0] o_sym,
    output logic [VW-1:0]    o_left,
    output logic [VW-1:0]    o_diag
);

    logic [SYM_W-1:0] r_ch;
    logic [VW-1:0]    r_row;
    t_wave_ctl        r_wave;
    logic [SYM_W-1:0] r_sym;
    logic [VW-1:0]    r_left;
    logic [VW-1:0]    r_diag;

    logic             w_en;
    logic             w_cost;
    logic [VW:0]      w_up1;
    logic [VW:0]      w_lf1;
    logic [VW:0]      w_dg;
    logic [VW:0]      w_min_a;
    logic [VW:0]      w_min;
    logic [VW-1:0]    w_new;
    logic             w_hit;
    logic [VW-1:0]    n_left;

    // cell lies inside the current reference word
    assign w_en = (i_ref_len >= LW'(IDX));

    // three-way minimum: deletion, insertion, substitution/match
    assign w_cost  = (r_ch != i_sym);
    assign w_up1   = {1'b0, r_row} + {{VW{1'b0}}, 1'b1};
    assign w_lf1   = {1'b0, i_left} + {{VW{1'b0}}, 1'b1};
    assign w_dg    = {1'b0, i_diag} + {{VW{1'b0}}, w_cost};
    assign w_min_a = (w_up1 < w_lf1) ? w_up1 : w_lf1;
    assign w_min   = (w_min_a < w_dg) ? w_min_a : w_dg;
    assign w_new   = w_min[VW-1:0];

    assign w_hit = i_wave.vld && w_en;

    // value handed on: new entry, current entry for a read token, else pass-through
    always_comb begin
        priority if (w_hit && i_wave.upd) begin
            n_left = w_new;
        end else if (w_hit) begin
            n_left = r_row;
        end else begin
            n_left = i_left;
        end
    end

    // token flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave <= '0;
        end else if (i_ctl.adv) begin
            r_wave <= i_wave;
        end
    end

    // reference character store
    always_ff @(posedge i_clk) begin
        if (i_ctl.ref_we && (i_wr_pos == LW'(IDX - 1))) begin
            r_ch <= i_ref_sym;
        end
    end

    // row entry
    always_ff @(posedge i_clk) begin
        if (i_ctl.init && w_en) begin
            r_row <= VW'(IDX);
        end else if (i_ctl.adv && w_hit && i_wave.upd) begin
            r_row <= w_new;
        end
    end

    // token payload to the next cell; diag is this entry before the update
    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_sym  <= i_sym;
            r_left <= n_left;
            r_diag <= r_row;
        end
    end

    assign o_wave = r_wave;
    assign o_sym  = r_sym;
    assign o_left = r_left;
    assign o_diag = r_diag;

endmodule

// ===== rtl/core/edit_distance_engine.sv =====
// Top level: Levenshtein distance engine built from a systolic chain of cells.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+------------------------------------------
//   in      | to block  | i_in_valid / o_in_ready   | i_func i_symbol i_has_symbol i_first i_last
//   out     | from block| o_out_valid / i_out_ready | o_distance o_overflow
//
// Candidate characters that continue a word are taken one per cycle while no held
// result freezes the chain; each one launches a wavefront that crosses MAX_LEN+1
// chain stages, and its result is registered at the chain end.
// A reference request, or the first request of a new candidate, waits until the
// chain has no token left in it and no held result freezes the chain.
// Reset is synchronous, active low, and clears lengths, flags and token valids.
// A result held at the output while the chain end carries another freezes the chain.
module edit_distance_engine
    import ede_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_func,
    input  logic [SYM_W-1:0]  i_symbol,
    input  logic              i_has_symbol,
    input  logic              i_first,
    input  logic              i_last,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [DIST_W-1:0] o_distance,
    output logic              o_overflow
);

    localparam int LW    = $clog2(MAX_LEN + 1);
    localparam int VW_RAW = $clog2(2 * MAX_LEN + 1);
    localparam int VW    = (VW_RAW > DIST_W) ? VW_RAW : DIST_W;
    localparam int CW    = $clog2(MAX_LEN + 2);

    // chain stages; stage 0 is the launch register here
    t_wave_ctl        s_wave [0:MAX_LEN];
    logic [SYM_W-1:0] s_sym  [0:MAX_LEN];
    logic [VW-1:0]    s_left [0:MAX_LEN];
    logic [VW-1:0]    s_diag [0:MAX_LEN];

    logic [LW-1:0]     r_ref_len;
    logic              r_ref_over;
    logic              r_ovf;
    logic [LW-1:0]     r_cand_len;
    logic [CW-1:0]     r_inflight;
    logic [VW-1:0]     r_row0;
    t_wave_ctl         r_wave0;
    logic [SYM_W-1:0]  r_sym0;
    logic [VW-1:0]     r_left0;
    logic [VW-1:0]     r_diag0;
    logic              r_out_vld;
    logic [DIST_W-1:0] r_out_dist;
    logic              r_out_ovf;

    logic [LW-1:0]     n_ref_len;
    logic              n_ref_over;
    logic              n_ovf;
    logic [CW-1:0]     n_inflight;

    logic              w_is_cand;
    logic              w_drain_req;
    t_wave_ctl         w_end;
    logic              w_adv;
    logic              w_acc;
    logic              w_acc_ref;
    logic              w_acc_cand;
    logic [LW-1:0]     w_cand_len;
    logic [LW-1:0]     w_ref_pos;
    logic              w_cand_room;
    logic              w_ref_room;
    logic [VW-1:0]     w_row0;
    logic [VW-1:0]     w_col_top;
    logic              w_upd;
    logic              w_launch;
    logic              w_leave;
    logic              w_ovf_nx;
    t_cell_ctl         w_ctl;

    // request decode and flow control
    assign w_is_cand   = (i_func == FUNC_CAND);
    assign w_drain_req = !w_is_cand || i_first;
    assign w_end       = s_wave[MAX_LEN];
    assign w_adv       = !(w_end.vld && w_end.rd && r_out_vld && !i_out_ready);
    assign o_in_ready  = w_adv && (!w_drain_req || (r_inflight == '0));
    assign w_acc       = i_in_valid && o_in_ready;
    assign w_acc_ref   = w_acc && !w_is_cand;
    assign w_acc_cand  = w_acc && w_is_cand;

    // lengths as seen after an optional word start
    assign w_cand_len  = i_first ? '0 : r_cand_len;
    assign w_ref_pos   = i_first ? '0 : r_ref_len;
    assign w_cand_room = (w_cand_len < LW'(MAX_LEN));
    assign w_ref_room  = (w_ref_pos < LW'(MAX_LEN));
    assign w_row0      = i_first ? '0 : r_row0;
    assign w_col_top   = VW'(w_cand_len) + VW'(1);

    assign w_upd    = i_has_symbol && w_cand_room;
    assign w_launch = w_acc_cand && (w_upd || i_last);
    assign w_leave  = w_adv && w_end.vld;
    assign w_ovf_nx = (i_first ? r_ref_over : r_ovf) || (i_has_symbol && !w_cand_room);

    assign w_ctl.adv    = w_adv;
    assign w_ctl.init   = w_acc_cand && i_first;
    assign w_ctl.ref_we = w_acc_ref && i_has_symbol && w_ref_room;

    // reference length and overflow tracking
    always_comb begin
        n_ref_len  = r_ref_len;
        n_ref_over = r_ref_over;
        n_ovf      = r_ovf;
        if (w_acc_ref) begin
            n_ref_len = w_ref_pos;
            if (i_first) begin
                n_ref_over = 1'b0;
                n_ovf      = 1'b0;
            end
            if (i_has_symbol) begin
                if (w_ref_room) begin
                    n_ref_len = w_ref_pos + LW'(1);
                end else begin
                    n_ref_over = 1'b1;
                    n_ovf      = 1'b1;
                end
            end
        end else if (w_acc_cand) begin
            n_ovf = w_ovf_nx;
        end
    end

    // tokens in the chain
    always_comb begin
        n_inflight = r_inflight;
        if (w_launch && !w_leave) begin
            n_inflight = r_inflight + CW'(1);
        end else if (!w_launch && w_leave) begin
            n_inflight = r_inflight - CW'(1);
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_len  <= '0;
            r_ref_over <= 1'b0;
            r_ovf      <= 1'b0;
            r_cand_len <= '0;
            r_inflight <= '0;
            r_wave0    <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_ref_len  <= n_ref_len;
            r_ref_over <= n_ref_over;
            r_ovf      <= n_ovf;
            r_inflight <= n_inflight;
            if (w_acc_cand) begin
                r_cand_len <= w_upd ? (w_cand_len + LW'(1)) : w_cand_len;
            end
            if (w_adv) begin
                r_wave0.vld <= w_launch;
                r_wave0.upd <= w_launch && w_upd;
                r_wave0.rd  <= w_launch && i_last;
                r_wave0.ovf <= w_launch && w_ovf_nx;
            end
            if (w_adv && w_end.vld && w_end.rd) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // row entry zero and launch payload
    always_ff @(posedge i_clk) begin
        if (w_acc_cand && (i_first || w_upd)) begin
            r_row0 <= w_upd ? w_col_top : '0;
        end
        if (w_adv) begin
            r_sym0  <= i_symbol;
            r_left0 <= w_upd ? w_col_top : w_row0;
            r_diag0 <= w_row0;
        end
    end

    // result register, distance saturated to the field
    always_ff @(posedge i_clk) begin
        if (w_adv && w_end.vld && w_end.rd) begin
            r_out_dist <= (s_left[MAX_LEN] > VW'(DIST_SAT)) ? DIST_SAT
                                                             : s_left[MAX_LEN][DIST_W-1:0];
            r_out_ovf  <= w_end.ovf;
        end
    end

    assign s_wave[0] = r_wave0;
    assign s_sym[0]  = r_sym0;
    assign s_left[0] = r_left0;
    assign s_diag[0] = r_diag0;

    // chain of cells, one per reference position
    for (genvar g = 1; g <= MAX_LEN; g++) begin : g_cell
        ede_cell #(
            .IDX (g),
            .LW  (LW),
            .VW  (VW)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_ref_len (r_ref_len),
            .i_wr_pos  (w_ref_pos),
            .i_ref_sym (i_symbol),
            .i_wave    (s_wave[g-1]),
            .i_sym     (s_sym[g-1]),
            .i_left    (s_left[g-1]),
            .i_diag    (s_diag[g-1]),
            .o_wave    (s_wave[g]),
            .o_sym     (s_sym[g]),
            .o_left    (s_left[g]),
            .o_diag    (s_diag[g])
        );
    end

    assign o_out_valid = r_out_vld;
    assign o_distance  = r_out_dist;
    assign o_overflow  = r_out_ovf;

endmodule

// ===== dv/edit_distance_engine_test.sv =====
// Self-checking testbench for the edit distance engine: directed words, then random word streams.
module edit_distance_engine_test;
    import ede_pkg::*;

    localparam int ITEMS_TARGET = 1300;
    localparam int CALM_FROM    = 1100;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int SETTLE_CYCLES = 2 * (MAX_LEN_DEF + 1) + 20;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              overflow;
    } t_dist_result;

    typedef struct {
        logic [SYM_W-1:0] sym;
        bit               has;
    } t_char;
    typedef t_char t_word[$];

    // Tracks reference store and DP row, queues the distances the block owes
    class edit_distance_scoreboard;
        logic [SYM_W-1:0] ref_word [MAX_LEN_DEF];
        int               ref_len;
        int               dp_row [MAX_LEN_DEF+1];
        int               cand_len;
        bit               len_ovf;
        bit               ref_ovf;
        int               rows_written = -1;
        t_dist_result     expected_distances[$];
        int               requests;
        int               checked;
        int               overflow_results;
        int               errors;

        function int pending();
            return expected_distances.size();
        endfunction

        // a candidate may go on without first only over row entries set since reset
        function bit can_continue();
            return ref_len <= rows_written;
        endfunction

        // one DP column for a candidate character
        function void fold_candidate_char(logic [SYM_W-1:0] sym);
            int diag;
            int up;
            int best;
            diag = dp_row[0];
            dp_row[0] = cand_len + 1;
            for (int i = 1; i <= ref_len; i++) begin
                up = dp_row[i];
                best = up + 1;
                if (dp_row[i-1] + 1 < best) best = dp_row[i-1] + 1;
                if (diag + ((ref_word[i-1] == sym) ? 0 : 1) < best)
                    best = diag + ((ref_word[i-1] == sym) ? 0 : 1);
                dp_row[i] = best;
                diag = up;
            end
        endfunction

        function void note_request(bit func, logic [SYM_W-1:0] sym, bit has, bit first,
                                   bit last);
            t_dist_result res;
            int d;
            requests++;
            if (func == FUNC_REF) begin
                if (first) begin
                    ref_len = 0;
                    ref_ovf = 1'b0;
                    len_ovf = 1'b0;
                end
                if (has) begin
                    if (ref_len < MAX_LEN_DEF) begin
                        ref_word[ref_len] = sym;
                        ref_len++;
                    end else begin
                        ref_ovf = 1'b1;
                        len_ovf = 1'b1;
                    end
                end
            end else begin
                if (first) begin
                    for (int i = 0; i <= ref_len; i++) dp_row[i] = i;
                    cand_len = 0;
                    len_ovf = ref_ovf;
                    if (ref_len > rows_written) rows_written = ref_len;
                end
                if (has) begin
                    if (cand_len < MAX_LEN_DEF) begin
                        fold_candidate_char(sym);
                        cand_len++;
                    end else begin
                        len_ovf = 1'b1;
                    end
                end
                if (last) begin
                    d = dp_row[ref_len];
                    res.distance = (d > DIST_SAT) ? DIST_SAT : d[DIST_W-1:0];
                    res.overflow = len_ovf;
                    expected_distances = {expected_distances, res};
                end
            end
        endfunction

        function void check_result(logic [DIST_W-1:0] distance, logic overflow);
            t_dist_result exp_res;
            if (expected_distances.size() == 0) begin
                errors++;
                $display("%0t: result with nothing expected: distance %0d overflow %0b",
                         $time, distance, overflow);
                return;
            end
            exp_res = expected_distances.pop_front();
            checked++;
            if (exp_res.overflow) overflow_results++;
            if (distance !== exp_res.distance) begin
                errors++;
                $display("%0t: distance mismatch: expected %0d, actual %0d",
                         $time, exp_res.distance, distance);
            end
            if (overflow !== exp_res.overflow) begin
                errors++;
                $display("%0t: overflow mismatch: expected %0b, actual %0b",
                         $time, exp_res.overflow, overflow);
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic              i_func;
    logic [SYM_W-1:0]  i_symbol;
    logic              i_has_symbol;
    logic              i_first;
    logic              i_last;
    logic              o_out_valid;
    logic              i_out_ready;
    logic [DIST_W-1:0] o_distance;
    logic              o_overflow;

    edit_distance_scoreboard sb;
    bit                      calm = 1'b0;
    int unsigned             cycle_count = 0;

    edit_distance_engine #(
        .MAX_LEN(MAX_LEN_DEF)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_func      (i_func),
        .i_symbol    (i_symbol),
        .i_has_symbol(i_has_symbol),
        .i_first     (i_first),
        .i_last      (i_last),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_distance  (o_distance),
        .o_overflow  (o_overflow)
    );

    always #5 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d distances still outstanding", $time, sb.pending());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side: ready drops in bursts until the calm tail
    initial begin
        int n;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (!calm && $urandom_range(0, 2) == 0) begin
                n = $urandom_range(1, 10);
                @(negedge i_clk);
                i_out_ready <= 1'b0;
            end else begin
                n = $urandom_range(1, 20);
                @(negedge i_clk);
                i_out_ready <= 1'b1;
            end
            repeat (n - 1) @(negedge i_clk);
        end
    end

    // check every accepted result
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_distance, o_overflow);
    end

    function automatic logic [SYM_W-1:0] pick_symbol();
        logic [SYM_W-1:0] s;
        // small alphabet most of the time so words share characters
        if ($urandom_range(0, 3) != 0) s = 8'h61 + SYM_W'($urandom_range(0, 3));
        else s = SYM_W'($urandom_range(0, 255));
        return s;
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(0, 8);
        if (r < 95) return $urandom_range(9, 40);
        return $urandom_range(60, 70);
    endfunction

    function automatic t_word random_word(int len);
        t_word w;
        t_char c;
        repeat (len) begin
            c.sym = pick_symbol();
            c.has = 1'b1;
            w = {w, c};
        end
        return w;
    endfunction

    // a few substitutions, insertions and deletions on a word
    function automatic t_word mutate(t_word src);
        t_word w;
        t_char c;
        int pos;
        w = src;
        repeat ($urandom_range(0, 3)) begin
            c.sym = pick_symbol();
            c.has = 1'b1;
            pos = $urandom_range(0, w.size());
            case ($urandom_range(0, 2))
                0: w.insert(pos, c);
                1: if (pos < w.size()) w.delete(pos);
                default: if (pos < w.size()) w[pos] = c;
            endcase
        end
        return w;
    endfunction

    // drive one request and hold it until accepted
    task automatic send_request(bit func, logic [SYM_W-1:0] sym, bit has, bit first, bit last);
        @(negedge i_clk);
        i_in_valid   <= 1'b1;
        i_func       <= func;
        i_symbol     <= sym;
        i_has_symbol <= has;
        i_first      <= first;
        i_last       <= last;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        sb.note_request(func, sym, has, first, last);
    endtask

    task automatic hold_off(int n);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    task automatic maybe_pause();
        if (!calm && $urandom_range(0, 5) == 0) hold_off($urandom_range(1, 10));
    endtask

    task automatic drain_results();
        hold_off(1);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // a whole word; an empty word is one request with no character
    task automatic send_word(bit func, t_word w, bit end_last);
        if (w.size() == 0) begin
            maybe_pause();
            send_request(func, SYM_W'($urandom_range(0, 255)), 1'b0, 1'b1, end_last);
            return;
        end
        foreach (w[k]) begin
            if (k > 0 && $urandom_range(0, 24) == 0) begin
                maybe_pause();
                send_request(func, SYM_W'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);
            end
            maybe_pause();
            send_request(func, w[k].sym, w[k].has, k == 0, end_last && k == w.size() - 1);
        end
    endtask

    initial begin
        t_word ref_w;
        t_word cand_w;
        t_char c;
        int    seq;
        int    r;
        bit    f;
        bit    fst;

        sb = new;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_func       = FUNC_REF;
        i_symbol     = '0;
        i_has_symbol = 1'b0;
        i_first      = 1'b0;
        i_last       = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty reference against empty candidate
        send_request(FUNC_REF, 8'h00, 1'b0, 1'b1, 1'b0);
        send_request(FUNC_CAND, 8'hFF, 1'b0, 1'b1, 1'b1);
        // extreme bytes; last on a reference request is ignored
        send_request(FUNC_REF, 8'h00, 1'b1, 1'b1, 1'b0);
        send_request(FUNC_REF, 8'hFF, 1'b1, 1'b0, 1'b1);
        send_request(FUNC_CAND, 8'hFF, 1'b1, 1'b1, 1'b0);
        send_request(FUNC_CAND, 8'h00, 1'b1, 1'b0, 1'b1);
        send_request(FUNC_CAND, 8'h00, 1'b1, 1'b1, 1'b0);
        send_request(FUNC_CAND, 8'hFF, 1'b1, 1'b0, 1'b1);
        // candidate goes on without first from the row as it stands
        send_request(FUNC_CAND, 8'h55, 1'b1, 1'b0, 1'b1);
        // empty candidate against a two-character reference
        send_request(FUNC_CAND, 8'hAA, 1'b0, 1'b1, 1'b1);
        // character-less request inside a candidate
        send_request(FUNC_CAND, 8'h00, 1'b1, 1'b1, 1'b0);
        send_request(FUNC_CAND, 8'h12, 1'b0, 1'b0, 1'b0);
        send_request(FUNC_CAND, 8'hFF, 1'b1, 1'b0, 1'b1);
        // reference reloaded while a candidate is open
        send_request(FUNC_CAND, 8'h61, 1'b1, 1'b1, 1'b0);
        send_request(FUNC_REF, 8'h61, 1'b1, 1'b1, 1'b0);
        send_request(FUNC_REF, 8'h62, 1'b1, 1'b0, 1'b0);
        send_request(FUNC_CAND, 8'h62, 1'b1, 1'b0, 1'b1);
        drain_results();

        // random word streams
        seq = 0;
        while (sb.requests < ITEMS_TARGET) begin
            if (sb.requests >= CALM_FROM) calm = 1'b1;
            r = $urandom_range(0, 99);
            if (seq < 2 || r < 85) begin
                // a reference, then candidates against it; the first two are at least full length
                if (seq == 0) begin
                    ref_w = random_word(MAX_LEN_DEF + 2);
                end else if (seq == 1) begin
                    ref_w.delete();
                    repeat (MAX_LEN_DEF) begin
                        c.sym = 8'h61 + SYM_W'($urandom_range(0, 3));
                        c.has = 1'b1;
                        ref_w = {ref_w, c};
                    end
                end else begin
                    ref_w = random_word(pick_len());
                end
                send_word(FUNC_REF, ref_w, $urandom_range(0, 3) == 0);
                repeat ($urandom_range(1, 4)) begin
                    if (seq == 0) begin
                        cand_w = random_word(MAX_LEN_DEF + 1);
                    end else if (seq == 1) begin
                        // no shared characters: distance is the full length
                        cand_w.delete();
                        repeat (MAX_LEN_DEF) begin
                            c.sym = 8'hF0 + SYM_W'($urandom_range(0, 15));
                            c.has = 1'b1;
                            cand_w = {cand_w, c};
                        end
                    end else if ($urandom_range(0, 9) < 7) begin
                        cand_w = mutate(ref_w);
                    end else begin
                        cand_w = random_word(pick_len());
                    end
                    send_word(FUNC_CAND, cand_w, 1'b1);
                end
            end else if (r < 93) begin
                // loose requests with random fields
                repeat ($urandom_range(1, 6)) begin
                    maybe_pause();
                    f = 1'($urandom_range(0, 1));
                    fst = 1'($urandom_range(0, 1));
                    if (f == FUNC_CAND && !sb.can_continue()) fst = 1'b1;
                    send_request(f, SYM_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                                 fst, 1'($urandom_range(0, 1)));
                end
            end else begin
                // open candidate, reference swapped under it, candidate finished
                send_word(FUNC_CAND, random_word(pick_len() + 1), 1'b0);
                send_word(FUNC_REF, random_word(pick_len()), 1'b0);
                cand_w = random_word($urandom_range(1, 4));
                foreach (cand_w[k]) begin
                    maybe_pause();
                    send_request(FUNC_CAND, cand_w[k].sym, 1'b1,
                                 k == 0 && !sb.can_continue(), k == cand_w.size() - 1);
                end
            end
            // sometimes hold the sender until every distance is back
            if ($urandom_range(0, 39) == 0) drain_results();
            seq++;
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Run covered %0d requests in %0d word sequences after the directed words,",
                 sb.requests, seq);
        $display("and checked %0d distances, %0d of them flagged as overflow.",
                 sb.checked, sb.overflow_results);
        if (sb.errors == 0 && sb.pending() == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end

endmodule
